// ===== design/chbd_pkg.sv =====
// Shared types and constants of the chunked body decoder.
`timescale 1ns / 1ps

package chbd_pkg;

    localparam int COUNT_WIDTH = 32;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_VT   = 8'h0B;
    localparam logic [7:0] CH_FF   = 8'h0C;

    typedef enum logic [2:0] {
        PH_LEAD   = 3'd0,
        PH_SIZE   = 3'd1,
        PH_DATA   = 3'd2,
        PH_OPT_CR = 3'd3,
        PH_OPT_LF = 3'd4,
        PH_TRAIL  = 3'd5,
        PH_DONE   = 3'd6
    } phase_t;

    typedef struct packed {
        phase_t                   phase;
        logic [COUNT_WIDTH-1:0]   remaining_bytes;
        logic [COUNT_WIDTH-1:0]   size_accum;
        logic                     number_closed;
        logic                     line_nonblank;
    } chbd_state_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } chbd_result_t;

endpackage

// ===== design/http_chunked_body_decoder_unit.sv =====
// Top level of the HTTP chunked body decoder: input register, state and result register.
`timescale 1ns / 1ps

// Channel   Handshake                     Payload
// input     data_valid / data_stall       in_byte
// result    result_valid / result_stall   out_byte, body_end
//
// One byte per cycle when not stalled: a word sits in the input register, its
// state update and result are formed combinationally and stored in the state
// and result registers.
// Reset (rst_n low) clears the phase, counters and valid flags at once.
// A stall on the result side while the result register is full holds the input
// register; data_stall then rises.

module http_chunked_body_decoder_unit
    import chbd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       data_valid,
    output logic       data_stall,
    input  logic [7:0] in_byte,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [7:0] out_byte,
    output logic       body_end
);

    logic         in_valid_reg;
    logic         in_valid_next;
    logic [7:0]   in_byte_reg;
    chbd_state_t  state_reg;
    chbd_state_t  state_next;
    chbd_result_t step_res;
    logic         out_free;
    logic         advance;
    logic         accept;

    assign advance    = in_valid_reg && out_free;
    assign data_stall = in_valid_reg && !out_free;
    assign accept     = data_valid && !data_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= in_byte;
        end
    end

    chbd_step u_step (
        .cur     (state_reg),
        .in_byte (in_byte_reg),
        .nxt     (state_next),
        .res     (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= '{phase: PH_LEAD, default: '0};
        end else
        begin
            in_valid_reg <= in_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    chbd_out_reg u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance && step_res.valid),
        .din          (step_res),
        .free         (out_free),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_byte     (out_byte),
        .body_end     (body_end)
    );

    a_data_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_DATA) |-> (state_reg.remaining_bytes != '0))
        else $error("chunk data phase with no bytes left");

    a_accum_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg.phase == PH_LEAD || state_reg.phase == PH_SIZE)
            |-> (state_reg.size_accum == '0 && !state_reg.number_closed))
        else $error("size accumulator not cleared outside a size line");

    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_DONE) |=> (state_reg.phase == PH_DONE))
        else $error("decoder left the done phase");

endmodule

// ===== design/chbd_step.sv =====
// Next-state and result logic for one body byte.
`timescale 1ns / 1ps

module chbd_step
    import chbd_pkg::*;
(
    input  chbd_state_t  cur,
    input  logic [7:0]   in_byte,
    output chbd_state_t  nxt,
    output chbd_result_t res
);

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SP) || (c == CH_TAB) || (c == CH_CR) || (c == CH_VT) || (c == CH_FF);
    endfunction

    function automatic chbd_state_t size_line(input chbd_state_t s, input logic [7:0] c);
        chbd_state_t r;
        logic        dv;
        logic [3:0]  d;
        r  = s;
        dv = 1'b0;
        d  = c[3:0];
        if (c >= 8'h30 && c <= 8'h39) begin
            dv = 1'b1;
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            dv = 1'b1;
            d  = c[3:0] + 4'd9;
        end
        if (c == CH_LF) begin
            if (s.size_accum == '0) begin
                r.phase         = PH_TRAIL;
                r.line_nonblank = 1'b0;
            end else begin
                r.remaining_bytes = s.size_accum;
                r.phase           = PH_DATA;
            end
            r.size_accum    = '0;
            r.number_closed = 1'b0;
        end else if (!(s.phase == PH_LEAD && is_blank(c))) begin
            r.phase = PH_SIZE;
            if (!s.number_closed) begin
                // A semicolon is not a hex digit, so it closes the number too.
                if (!dv) begin
                    r.number_closed = 1'b1;
                end else if (s.size_accum[COUNT_WIDTH-1 -: 4] != 4'd0) begin
                    r.size_accum = '1;
                end else begin
                    r.size_accum = {s.size_accum[COUNT_WIDTH-5:0], d};
                end
            end
        end
        return r;
    endfunction

    always_comb
    begin
        chbd_state_t fresh;
        fresh               = cur;
        fresh.phase         = PH_LEAD;
        fresh.size_accum    = '0;
        fresh.number_closed = 1'b0;
        nxt                 = cur;
        res                 = '0;
        unique case (cur.phase)
            PH_LEAD, PH_SIZE:
            begin
                nxt = size_line(cur, in_byte);
            end
            PH_DATA:
            begin
                nxt.remaining_bytes = cur.remaining_bytes - COUNT_WIDTH'(1);
                if (cur.remaining_bytes == {{(COUNT_WIDTH-1){1'b0}}, 1'b1})
                begin
                    nxt.phase = PH_OPT_CR;
                end
                res.valid = 1'b1;
                res.data  = in_byte;
            end
            PH_OPT_CR:
            begin
                if (in_byte == CH_CR)
                begin
                    nxt.phase = PH_OPT_LF;
                end else if (in_byte == CH_LF)
                begin
                    nxt.phase = PH_LEAD;
                end else
                begin
                    nxt = size_line(fresh, in_byte);
                end
            end
            PH_OPT_LF:
            begin
                if (in_byte == CH_LF)
                begin
                    nxt = fresh;
                end else
                begin
                    nxt = size_line(fresh, in_byte);
                end
            end
            PH_TRAIL:
            begin
                if (in_byte == CH_LF)
                begin
                    if (!cur.line_nonblank)
                    begin
                        nxt.phase = PH_DONE;
                        res.valid = 1'b1;
                        res.last  = 1'b1;
                    end else
                    begin
                        nxt.line_nonblank = 1'b0;
                    end
                end else if (!is_blank(in_byte))
                begin
                    nxt.line_nonblank = 1'b1;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

// ===== design/chbd_out_reg.sv =====
// Result register that holds a word until the downstream side takes it.
`timescale 1ns / 1ps

module chbd_out_reg
    import chbd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  chbd_result_t din,
    output logic         free,
    output logic         result_valid,
    input  logic         result_stall,
    output logic [7:0]   out_byte,
    output logic         body_end
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       end_reg;

    assign free = !valid_reg || !result_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= din.data;
            end_reg  <= din.last;
        end
    end

    assign result_valid = valid_reg;
    assign out_byte     = byte_reg;
    assign body_end     = end_reg;

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("result register loaded while occupied and stalled");

    a_end_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && end_reg) |-> (byte_reg == 8'd0))
        else $error("end word carries a nonzero byte");

    a_end_once: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && end_reg && !result_stall) |=> !(load && din.last))
        else $error("second end word follows the first");

endmodule
